/* src/binary_mask_box_count_core_macros.svh */
// Assertion macros shared by the box count RTL
`ifndef BINARY_MASK_BOX_COUNT_CORE_MACROS_SVH
`define BINARY_MASK_BOX_COUNT_CORE_MACROS_SVH

// plain property, sampled on clk_i, off during reset
`define BMBC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// overlapping implication, sampled on clk_i, off during reset
`define BMBC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

/* src/bmbc_pkg.sv */
// Constants, types and helper functions of the binary mask box counter
package bmbc_pkg;

  localparam int unsigned MaxKernel = 15;
  localparam int unsigned MaxWidth  = 1024;
  localparam int unsigned MaxHeight = 1024;

  localparam int unsigned KW       = 4;
  localparam int unsigned DimW     = 11;
  localparam int unsigned PixW     = 8;
  localparam int unsigned PosW     = 10;
  localparam int unsigned CntW     = 8;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 11;

  localparam int unsigned HistW     = MaxKernel;
  localparam int unsigned ColSumW   = $clog2(MaxKernel + 1);
  localparam int unsigned LaneW     = $clog2(MaxKernel);
  localparam int unsigned TreeLanes = 2 ** $clog2(MaxKernel);
  localparam int unsigned ColW      = $clog2(MaxWidth);
  localparam int unsigned RowW      = $clog2(MaxHeight);
  localparam int unsigned MaxPosW   = (ColW > RowW) ? ColW : RowW;
  localparam int unsigned CmpW      = ((MaxPosW > DimW) ? MaxPosW : DimW) + 1;

  localparam int unsigned FifoDepth = 3;
  localparam int unsigned FifoPtrW  = $clog2(FifoDepth);
  localparam int unsigned FifoCntW  = $clog2(FifoDepth + 1);
  localparam int unsigned OccW      = FifoCntW + 1;

  localparam logic [PixW-1:0] SetValue = 8'hFF;

  typedef logic [CfgIdxW-1:0] cfg_idx_t;
  localparam cfg_idx_t CfgKernelSize  = CfgIdxW'(0);
  localparam cfg_idx_t CfgImageWidth  = CfgIdxW'(1);
  localparam cfg_idx_t CfgImageHeight = CfgIdxW'(2);

  typedef struct packed {
    logic [PosW-1:0] center_row;
    logic [PosW-1:0] center_col;
    logic [CntW-1:0] set_count;
    logic            frame_last;
  } res_beat_t;

  typedef struct packed {
    logic          shift;
    logic          clear;
    logic [KW-1:0] k;
  } cell_ctrl_t;

  typedef logic [TreeLanes-1:0][ColSumW-1:0] tap_vec_t;

  function automatic logic [ColSumW-1:0] popcount(input logic [TreeLanes-1:0] v);
    logic [ColSumW-1:0] acc [TreeLanes];
    for (int i = 0; i < TreeLanes; i++) begin
      acc[i] = ColSumW'(v[i]);
    end
    for (int s = TreeLanes / 2; s > 0; s = s / 2) begin
      for (int i = 0; i < s; i++) begin
        acc[i] = acc[2*i] + acc[2*i+1];
      end
    end
    return acc[0];
  endfunction

  function automatic logic [CntW-1:0] tree_sum(input tap_vec_t taps);
    logic [CntW-1:0] acc [TreeLanes];
    for (int i = 0; i < TreeLanes; i++) begin
      acc[i] = CntW'(taps[i]);
    end
    for (int s = TreeLanes / 2; s > 0; s = s / 2) begin
      for (int i = 0; i < s; i++) begin
        acc[i] = acc[2*i] + acc[2*i+1];
      end
    end
    return acc[0];
  endfunction

endpackage

/* src/bmbc_if.sv */
// Pixel and result stream interfaces of the box counter
interface bmbc_pix_if;
  logic                      valid;
  logic                      ready;
  logic [bmbc_pkg::PixW-1:0] mask_pixel;
  logic                      frame_start;

  modport source (output valid, output mask_pixel, output frame_start, input ready);
  modport sink (input valid, input mask_pixel, input frame_start, output ready);
endinterface

interface bmbc_res_if;
  logic                      valid;
  logic                      ready;
  logic [bmbc_pkg::PosW-1:0] center_row;
  logic [bmbc_pkg::PosW-1:0] center_col;
  logic [bmbc_pkg::CntW-1:0] set_count;
  logic                      frame_last;

  modport source (output valid, output center_row, output center_col, output set_count,
                  output frame_last, input ready);
  modport sink (input valid, input center_row, input center_col, input set_count,
                input frame_last, output ready);
endinterface

/* src/bmbc_ram.sv */
// Generic single-write, single-read RAM with registered read data
module bmbc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* src/bmbc_sum_cell.sv */
// One cell of the recent column sum shift line, with its masked window tap
module bmbc_sum_cell (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  bmbc_pkg::cell_ctrl_t            ctrl_i,
  input  logic [bmbc_pkg::LaneW-1:0]      lane_i,
  input  logic [bmbc_pkg::ColSumW-1:0]    data_i,
  output logic [bmbc_pkg::ColSumW-1:0]    data_o,
  output logic [bmbc_pkg::ColSumW-1:0]    tap_o
);

  logic [bmbc_pkg::ColSumW-1:0] val_q, val_d;

  // row start empties every cell but the first
  always_comb begin
    val_d = data_i;
    if (ctrl_i.clear && (lane_i != '0)) begin
      val_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_q <= '0;
    end else if (ctrl_i.shift) begin
      val_q <= val_d;
    end
  end

  assign data_o = val_q;
  assign tap_o  = (int'(lane_i) < int'(ctrl_i.k)) ? val_d : '0;

endmodule

/* src/bmbc_res_fifo.sv */
// Small result queue that decouples the pipeline from the output stall
module bmbc_res_fifo (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push_i,
  input  bmbc_pkg::res_beat_t           push_beat_i,
  output logic [bmbc_pkg::FifoCntW-1:0] count_o,
  bmbc_res_if.source                    res_o
);

  bmbc_pkg::res_beat_t           mem_q [bmbc_pkg::FifoDepth];
  logic [bmbc_pkg::FifoPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [bmbc_pkg::FifoCntW-1:0] count_q;
  logic                          pop;

  function automatic logic [bmbc_pkg::FifoPtrW-1:0] ptr_inc(
    input logic [bmbc_pkg::FifoPtrW-1:0] p
  );
    return (p == bmbc_pkg::FifoPtrW'(bmbc_pkg::FifoDepth - 1)) ? '0 : p + 1'b1;
  endfunction

  assign pop = res_o.valid && res_o.ready;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_beat_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ptr_inc(wr_ptr_q);
      end
      if (pop) begin
        rd_ptr_q <= ptr_inc(rd_ptr_q);
      end
      if (push_i && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  assign count_o          = count_q;
  assign res_o.valid      = (count_q != '0);
  assign res_o.center_row = mem_q[rd_ptr_q].center_row;
  assign res_o.center_col = mem_q[rd_ptr_q].center_col;
  assign res_o.set_count  = mem_q[rd_ptr_q].set_count;
  assign res_o.frame_last = mem_q[rd_ptr_q].frame_last;

endmodule

/* src/binary_mask_box_count_core.sv */
// Binary mask box counter: per-pixel set count over a square window, top level
//
// Takes one mask pixel per clock in raster order while ready is high and, for
// every interior centre, delivers the number of set (255) pixels in the ksize
// x ksize window through stage one and the result queue once the bottom-right
// pixel of that window is accepted. The sustained rate is one pixel per cycle
// when not stalled, set by the read-modify-write of the per-column history
// RAM (read in the accept cycle, written the next, with a bypass when one
// column is hit twice in a row); the window sum is a row of shift cells
// feeding an adder tree. A three-entry result queue lets pixels keep flowing
// while a result waits. After reset the history RAM is cleared one column per
// cycle, with no pixel accepted; configuration writes are taken at any time.
`include "binary_mask_box_count_core_macros.svh"

module binary_mask_box_count_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bmbc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [bmbc_pkg::CfgDataW-1:0] cfg_data_i,
  bmbc_pix_if.sink                      pix_i,
  bmbc_res_if.source                    res_o
);

  // configuration
  logic [bmbc_pkg::KW-1:0]   kernel_size_q;
  logic [bmbc_pkg::DimW-1:0] image_width_q, image_height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kernel_size_q  <= bmbc_pkg::KW'(3);
      image_width_q  <= bmbc_pkg::DimW'(640);
      image_height_q <= bmbc_pkg::DimW'(480);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        bmbc_pkg::CfgKernelSize:  kernel_size_q  <= cfg_data_i[bmbc_pkg::KW-1:0];
        bmbc_pkg::CfgImageWidth:  image_width_q  <= cfg_data_i[bmbc_pkg::DimW-1:0];
        bmbc_pkg::CfgImageHeight: image_height_q <= cfg_data_i[bmbc_pkg::DimW-1:0];
        default: ;
      endcase
    end
  end

  logic [bmbc_pkg::KW-1:0]    k_eff, r_eff;
  logic [bmbc_pkg::DimW-1:0]  w_eff, h_eff;
  logic [bmbc_pkg::HistW-1:0] kmask;

  always_comb begin
    k_eff = kernel_size_q;
    if (int'(k_eff) > bmbc_pkg::MaxKernel) begin
      k_eff = bmbc_pkg::KW'(bmbc_pkg::MaxKernel);
    end
    if (!k_eff[0] && (k_eff != '0)) begin
      k_eff = k_eff - 1'b1;
    end
    r_eff = (k_eff == '0) ? '0 : ((k_eff - 1'b1) >> 1);

    w_eff = image_width_q;
    if (w_eff == '0) begin
      w_eff = bmbc_pkg::DimW'(1);
    end else if (int'(w_eff) > bmbc_pkg::MaxWidth) begin
      w_eff = bmbc_pkg::DimW'(bmbc_pkg::MaxWidth);
    end
    h_eff = image_height_q;
    if (h_eff == '0) begin
      h_eff = bmbc_pkg::DimW'(1);
    end else if (int'(h_eff) > bmbc_pkg::MaxHeight) begin
      h_eff = bmbc_pkg::DimW'(bmbc_pkg::MaxHeight);
    end

    for (int i = 0; i < bmbc_pkg::HistW; i++) begin
      kmask[i] = (i < int'(k_eff));
    end
  end

  // clearing pass over the history RAM
  logic                      clr_active_q;
  logic [bmbc_pkg::ColW-1:0] clr_addr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_active_q <= 1'b1;
      clr_addr_q   <= '0;
    end else if (clr_active_q) begin
      clr_addr_q <= clr_addr_q + 1'b1;
      if (clr_addr_q == bmbc_pkg::ColW'(bmbc_pkg::MaxWidth - 1)) begin
        clr_active_q <= 1'b0;
      end
    end
  end

  // accept stage
  logic                          in_accept;
  logic [bmbc_pkg::FifoCntW-1:0] fifo_count;
  logic [bmbc_pkg::OccW-1:0]     occ;
  logic                          s1_valid_q, s1_emit_q;

  assign occ = bmbc_pkg::OccW'(fifo_count) + bmbc_pkg::OccW'(s1_valid_q && s1_emit_q);
  assign pix_i.ready = !clr_active_q && (occ < bmbc_pkg::OccW'(bmbc_pkg::FifoDepth));
  assign in_accept   = pix_i.valid && pix_i.ready;

  logic [bmbc_pkg::RowW-1:0] row_q, row_cur, row_d;
  logic [bmbc_pkg::ColW-1:0] col_q, col_cur, col_d;
  logic [bmbc_pkg::CmpW-1:0] row_x, col_x, r_x, w_x, h_x;
  logic                      emit, last, col_wrap;
  logic [bmbc_pkg::PosW-1:0] cen_row, cen_col;

  always_comb begin
    row_cur = pix_i.frame_start ? '0 : row_q;
    col_cur = pix_i.frame_start ? '0 : col_q;
    row_x   = bmbc_pkg::CmpW'(row_cur);
    col_x   = bmbc_pkg::CmpW'(col_cur);
    r_x     = bmbc_pkg::CmpW'(r_eff);
    w_x     = bmbc_pkg::CmpW'(w_eff);
    h_x     = bmbc_pkg::CmpW'(h_eff);

    emit = (r_eff != '0) && (row_x < h_x) && (col_x < w_x) &&
           (row_x >= (r_x << 1)) && (col_x >= (r_x << 1));
    last = (row_x == h_x - 1'b1) && (col_x == w_x - 1'b1);
    cen_row = bmbc_pkg::PosW'(row_x - r_x);
    cen_col = bmbc_pkg::PosW'(col_x - r_x);

    col_wrap = (col_x + 1'b1) >= w_x;
    if (col_wrap) begin
      col_d = '0;
      row_d = ((row_x + 1'b1) >= h_x) ? '0 : bmbc_pkg::RowW'(row_x + 1'b1);
    end else begin
      col_d = bmbc_pkg::ColW'(col_x + 1'b1);
      row_d = row_cur;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
    end else if (in_accept) begin
      row_q <= row_d;
      col_q <= col_d;
    end
  end

  // stage one: column history update and window sum
  logic                      s1_bit_q, s1_col0_q, s1_last_q;
  logic [bmbc_pkg::ColW-1:0] s1_ci_q;
  logic [bmbc_pkg::PosW-1:0] s1_row_q, s1_col_q;
  logic                      hazard_q;
  logic [bmbc_pkg::HistW-1:0] fwd_q, old_hist, new_hist, ram_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      hazard_q   <= 1'b0;
    end else begin
      s1_valid_q <= in_accept;
      hazard_q   <= in_accept && s1_valid_q && (col_cur == s1_ci_q);
    end
  end

  always_ff @(posedge clk_i) begin
    fwd_q <= new_hist;
    if (in_accept) begin
      s1_bit_q  <= (pix_i.mask_pixel == bmbc_pkg::SetValue);
      s1_emit_q <= emit;
      s1_last_q <= last;
      s1_col0_q <= (col_cur == '0);
      s1_ci_q   <= col_cur;
      s1_row_q  <= cen_row;
      s1_col_q  <= cen_col;
    end
  end

  assign old_hist = hazard_q ? fwd_q : ram_rdata;
  assign new_hist = {old_hist[bmbc_pkg::HistW-2:0], s1_bit_q} & kmask;

  logic                       ram_we;
  logic [bmbc_pkg::ColW-1:0]  ram_waddr;
  logic [bmbc_pkg::HistW-1:0] ram_wdata;

  assign ram_we    = clr_active_q || s1_valid_q;
  assign ram_waddr = clr_active_q ? clr_addr_q : s1_ci_q;
  assign ram_wdata = clr_active_q ? '0 : new_hist;

  bmbc_ram #(
    .Width (bmbc_pkg::HistW),
    .Depth (bmbc_pkg::MaxWidth)
  ) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (col_cur),
    .rdata_o (ram_rdata)
  );

  logic [bmbc_pkg::ColSumW-1:0] col_sum;
  bmbc_pkg::cell_ctrl_t         cell_ctrl;
  logic [bmbc_pkg::ColSumW-1:0] cell_data [bmbc_pkg::MaxKernel];
  bmbc_pkg::tap_vec_t           cell_tap;

  assign col_sum   = bmbc_pkg::popcount(bmbc_pkg::TreeLanes'(new_hist));
  assign cell_ctrl = '{shift: s1_valid_q, clear: s1_col0_q, k: k_eff};

  for (genvar g = 0; g < bmbc_pkg::MaxKernel; g++) begin : g_cell
    bmbc_sum_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (cell_ctrl),
      .lane_i (bmbc_pkg::LaneW'(g)),
      .data_i ((g == 0) ? col_sum : cell_data[(g == 0) ? 0 : g - 1]),
      .data_o (cell_data[g]),
      .tap_o  (cell_tap[g])
    );
  end

  for (genvar g = bmbc_pkg::MaxKernel; g < bmbc_pkg::TreeLanes; g++) begin : g_pad
    assign cell_tap[g] = '0;
  end

  bmbc_pkg::res_beat_t res_beat;
  logic                res_push;

  assign res_push = s1_valid_q && s1_emit_q;
  assign res_beat = '{center_row: s1_row_q,
                      center_col: s1_col_q,
                      set_count:  bmbc_pkg::tree_sum(cell_tap),
                      frame_last: s1_last_q};

  bmbc_res_fifo u_res_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_push),
    .push_beat_i (res_beat),
    .count_o     (fifo_count),
    .res_o       (res_o)
  );

  `BMBC_ASSERT_IMP(a_no_accept_clr, clr_active_q, !in_accept, "beat accepted during RAM clear")
  `BMBC_ASSERT_IMP(a_s1_from_accept, s1_valid_q, $past(in_accept), "stage one without a beat")
  `BMBC_ASSERT_IMP(a_fwd_needs_s1, hazard_q, s1_valid_q, "bypass set without stage one beat")
  `BMBC_ASSERT(a_queue_room, occ <= bmbc_pkg::OccW'(bmbc_pkg::FifoDepth), "result queue overrun")

endmodule
